// ===== src/sipu_pkg.sv =====
`timescale 1ns / 1ps
// sipu_pkg: shared types and constants for the saturating integer power unit
// payload structs, status codes and the multiplier status struct; no dependencies

package sipu_pkg;

  localparam int DATA_WIDTH_DEF = 64;
  localparam int FIELD_W = 64;
  localparam int STATUS_W = 2;

  localparam logic [STATUS_W-1:0] ST_OK  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OVF = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ZZ  = 2'd2;

  typedef struct packed {
    logic signed [FIELD_W-1:0] base;
    logic signed [FIELD_W-1:0] exponent;
  } in_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] power;
    logic [STATUS_W-1:0]       status;
  } out_t;

  typedef struct packed {
    logic done;
    logic big;
  } mul_sts_t;

endpackage

// ===== src/sipu_mul.sv =====
`timescale 1ns / 1ps
// sipu_mul: multi-cycle multiplier built from one half-width multiplier
// four partial products summed into a double-width accumulator; uses sipu_pkg

module sipu_mul #(
  parameter int DATA_WIDTH = sipu_pkg::DATA_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [DATA_WIDTH-1:0]   a,
  input  logic [DATA_WIDTH-1:0]   b,
  output logic [DATA_WIDTH-1:0]   prod,
  output sipu_pkg::mul_sts_t      sts
);

  localparam int H  = (DATA_WIDTH + 1) / 2;
  localparam int PW = 2 * H;
  localparam int AW = 2 * DATA_WIDTH;
  localparam logic [2:0] PH_LAST = 3'd4;

  logic                  active;
  logic [2:0]            ph;
  logic                  done;
  logic [DATA_WIDTH-1:0] opa;
  logic [DATA_WIDTH-1:0] opb;
  logic [PW-1:0]         preg;
  logic [AW-1:0]         accum;

  logic [H-1:0]  a_lo, a_hi, b_lo, b_hi;
  logic [H-1:0]  ma, mb;
  logic [AW-1:0] addend;

  assign a_lo = opa[H-1:0];
  assign b_lo = opb[H-1:0];
  assign a_hi = H'(opa >> H);
  assign b_hi = H'(opb >> H);

  // pick the operand pair for this phase
  always_comb begin
    case (ph)
      3'd0: begin
        ma = a_lo;
        mb = b_lo;
      end
      3'd1: begin
        ma = a_lo;
        mb = b_hi;
      end
      3'd2: begin
        ma = a_hi;
        mb = b_lo;
      end
      default: begin
        ma = a_hi;
        mb = b_hi;
      end
    endcase
  end

  // weight of the partial product registered in the previous phase
  always_comb begin
    case (ph)
      3'd1:    addend = AW'(preg);
      3'd2:    addend = AW'(preg) << H;
      3'd3:    addend = AW'(preg) << H;
      3'd4:    addend = AW'(preg) << (2 * H);
      default: addend = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      ph     <= '0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        ph     <= '0;
      end else if (active) begin
        ph <= ph + 3'd1;
        if (ph == PH_LAST) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      opa   <= a;
      opb   <= b;
      accum <= '0;
    end else if (active) begin
      preg <= PW'(ma) * PW'(mb);
      if (ph != 3'd0) begin
        accum <= accum + addend;
      end
    end
  end

  assign prod     = accum[DATA_WIDTH-1:0];
  assign sts.done = done;
  assign sts.big  = |accum[AW-1:DATA_WIDTH-1];

endmodule

// ===== src/saturating_integer_power_unit.sv =====
`timescale 1ns / 1ps
// saturating_integer_power_unit: signed power by square-and-multiply with overflow check
// special cases are answered from the setup state; else every set exponent bit multiplies the
//   accumulator and every bit below the top set bit squares the base, each product formed in sipu_mul
// throughput: one transfer at a time, the next is accepted as early as the strobe cycle
// reset: synchronous, clears the sequencer and multiplier control; results cannot be stalled
// uses sipu_pkg and sipu_mul

module saturating_integer_power_unit #(
  parameter int DATA_WIDTH = sipu_pkg::DATA_WIDTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  sipu_pkg::in_t  operands,
  output logic           done,
  output sipu_pkg::out_t result
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SETUP = 2'd1;
  localparam logic [1:0] S_STEP  = 2'd2;
  localparam logic [1:0] S_WAIT  = 2'd3;

  logic [1:0]            state, state_next;
  logic [DATA_WIDTH-1:0] bval, bval_next;
  logic [DATA_WIDTH-1:0] rem, rem_next;
  logic [DATA_WIDTH-1:0] acc, acc_next;
  logic [DATA_WIDTH-1:0] sq, sq_next;
  logic                  rneg, rneg_next;
  logic                  accdone, accdone_next;
  logic                  tgt, tgt_next;
  logic                  done_next;
  sipu_pkg::out_t        result_next;

  logic                  bneg;
  logic [DATA_WIDTH-1:0] mag;
  logic [DATA_WIDTH-1:0] acc_neg;
  logic                  mul_go;
  logic [DATA_WIDTH-1:0] mul_a;
  logic [DATA_WIDTH-1:0] mul_prod;
  sipu_pkg::mul_sts_t    mul_sts;

  assign bneg    = bval[DATA_WIDTH-1];
  assign mag     = bneg ? (~bval + DATA_WIDTH'(1)) : bval;
  assign acc_neg = ~acc + DATA_WIDTH'(1);
  assign busy    = (state != S_IDLE);

  sipu_mul #(.DATA_WIDTH(DATA_WIDTH)) u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_go),
    .a     (mul_a),
    .b     (sq),
    .prod  (mul_prod),
    .sts   (mul_sts)
  );

  always_comb begin
    state_next   = state;
    bval_next    = bval;
    rem_next     = rem;
    acc_next     = acc;
    sq_next      = sq;
    rneg_next    = rneg;
    accdone_next = accdone;
    tgt_next     = tgt;
    done_next    = 1'b0;
    result_next  = result;
    mul_go       = 1'b0;
    mul_a        = acc;
    case (state)
      S_IDLE: begin
        if (start) begin
          bval_next  = operands.base[DATA_WIDTH-1:0];
          rem_next   = operands.exponent[DATA_WIDTH-1:0];
          state_next = S_SETUP;
        end
      end
      S_SETUP: begin
        result_next.power = '0;
        if (bval == '0 && rem == '0) begin
          result_next.status = sipu_pkg::ST_ZZ;
          done_next          = 1'b1;
          state_next         = S_IDLE;
        end else if (rem[DATA_WIDTH-1]) begin
          result_next.status = sipu_pkg::ST_OK;
          done_next          = 1'b1;
          state_next         = S_IDLE;
        end else if (rem == '0) begin
          result_next.power  = sipu_pkg::FIELD_W'(1);
          result_next.status = sipu_pkg::ST_OK;
          done_next          = 1'b1;
          state_next         = S_IDLE;
        end else if (mag[DATA_WIDTH-1]) begin
          result_next.status = sipu_pkg::ST_OVF;
          done_next          = 1'b1;
          state_next         = S_IDLE;
        end else begin
          acc_next     = DATA_WIDTH'(1);
          sq_next      = mag;
          rneg_next    = bneg & rem[0];
          accdone_next = 1'b0;
          state_next   = S_STEP;
        end
      end
      S_STEP: begin
        if (rem[0] && !accdone) begin
          mul_go     = 1'b1;
          mul_a      = acc;
          tgt_next   = 1'b0;
          state_next = S_WAIT;
        end else begin
          rem_next     = rem >> 1;
          accdone_next = 1'b0;
          if (rem[DATA_WIDTH-1:1] != '0) begin
            mul_go     = 1'b1;
            mul_a      = sq;
            tgt_next   = 1'b1;
            state_next = S_WAIT;
          end else begin
            result_next.power  = sipu_pkg::FIELD_W'(signed'(rneg ? acc_neg : acc));
            result_next.status = sipu_pkg::ST_OK;
            done_next          = 1'b1;
            state_next         = S_IDLE;
          end
        end
      end
      S_WAIT: begin
        if (mul_sts.done) begin
          if (mul_sts.big) begin
            result_next.power  = '0;
            result_next.status = sipu_pkg::ST_OVF;
            done_next          = 1'b1;
            state_next         = S_IDLE;
          end else begin
            if (tgt) begin
              sq_next = mul_prod;
            end else begin
              acc_next     = mul_prod;
              accdone_next = 1'b1;
            end
            state_next = S_STEP;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    bval    <= bval_next;
    rem     <= rem_next;
    acc     <= acc_next;
    sq      <= sq_next;
    rneg    <= rneg_next;
    accdone <= accdone_next;
    tgt     <= tgt_next;
    result  <= result_next;
  end

endmodule

// ===== src/sipu_chk.sv =====
`timescale 1ns / 1ps
// sipu_chk: port-level checks for the saturating integer power unit
// bound to saturating_integer_power_unit; uses sipu_pkg

module sipu_chk (
  input logic           clk,
  input logic           rst,
  input logic           start,
  input logic           busy,
  input logic           done,
  input sipu_pkg::out_t result
);

  // an accepted transfer keeps the unit busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted transfer did not raise busy");

  // a result only follows a busy cycle, and releases the unit
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy) && !busy)
    else $error("result strobe without preceding work");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.status == sipu_pkg::ST_OK || result.status == sipu_pkg::ST_OVF ||
              result.status == sipu_pkg::ST_ZZ))
    else $error("undefined status code");

  // errors always return a zero power
  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    done && result.status != sipu_pkg::ST_OK |-> result.power == '0)
    else $error("nonzero power with error status");

endmodule

bind saturating_integer_power_unit sipu_chk u_chk (.*);
